@@ src/stfs_pkg.sv @@
// shared types and constants of the sorted table forward search unit
`default_nettype none

package stfs_pkg;

  // fixed field widths
  localparam int unsigned ADDR_W   = 12;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned TIME_W   = 31;

  // defaults for the top level parameters
  localparam int unsigned DEF_TABLE_DEPTH    = 4096;
  localparam int unsigned DEF_NEURON_ID_BITS = 24;
  localparam int unsigned DEF_PAYLOAD_BITS   = 32;

  // item operation codes
  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_RESTART = 2'd1,
    OP_SEARCH  = 2'd2,
    OP_SEEK    = 2'd3
  } op_e;

  // result status codes
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_TIME      = 2'd1,
    STAT_BACKWARD  = 2'd2,
    STAT_UNORDERED = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic {
    CFG_TABLE_OFFSET = 1'b0,
    CFG_TABLE_COUNT  = 1'b1
  } cfg_idx_e;

  // controller to datapath commands
  typedef struct packed {
    logic capture;  // latch the accepted transaction
    logic exec;     // carry out the operation
    logic scan;     // evaluate the entry read last cycle
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_needed;  // search goes on into the table
    logic scan_done;    // the entry under evaluation ends the search
  } sts_t;

endpackage

`default_nettype wire

@@ src/stfs_ctrl.sv @@
// controller state machine of the sorted table forward search unit
`default_nettype none

module stfs_ctrl
  import stfs_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic start_i,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o,
  output logic      busy_o,
  output logic      result_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_EXEC = 3'b010,
    ST_SCAN = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        if (sts_i.scan_needed) begin
          state_d = ST_SCAN;
        end else begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (sts_i.scan_done) begin
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // state and result strobe registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

endmodule

`default_nettype wire

@@ src/stfs_datapath.sv @@
// datapath of the sorted table forward search unit: table, cursor and result
`default_nettype none

module stfs_datapath
  import stfs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH    = DEF_TABLE_DEPTH,
  parameter int unsigned NEURON_ID_BITS = DEF_NEURON_ID_BITS,
  parameter int unsigned PAYLOAD_BITS   = DEF_PAYLOAD_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire cmd_t                      cmd_i,
  output sts_t                           sts_o,
  // accepted transaction fields
  input  wire logic [1:0]                op_i,
  input  wire logic [ADDR_W-1:0]         address_i,
  input  wire logic [NEURON_ID_BITS-1:0] entry_source_i,
  input  wire logic [PAYLOAD_BITS-1:0]   entry_data_i,
  input  wire logic [NEURON_ID_BITS-1:0] neuron_id_i,
  input  wire logic [TIME_W-1:0]         time_ms_i,
  // configuration writes
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_index_i,
  input  wire logic [COUNT_W-1:0]        cfg_data_i,
  // result fields
  output logic                           found_o,
  output logic [NEURON_ID_BITS-1:0]      result_source_o,
  output logic [PAYLOAD_BITS-1:0]        result_data_o,
  output logic [ADDR_W-1:0]              result_index_o,
  output logic [1:0]                     status_o
);

  localparam int unsigned IW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned WW = (CW > COUNT_W + 1) ? CW : COUNT_W + 1;
  localparam logic [WW-1:0] DEPTH_W = WW'(TABLE_DEPTH);

  // table memory
  logic [NEURON_ID_BITS-1:0] src_mem [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0]   dat_mem [TABLE_DEPTH];

  // latched transaction
  op_e                       op_q;
  logic [ADDR_W-1:0]         addr_q;
  logic [NEURON_ID_BITS-1:0] esrc_q;
  logic [PAYLOAD_BITS-1:0]   edat_q;
  logic [NEURON_ID_BITS-1:0] nid_q;
  logic [TIME_W-1:0]         time_q;

  // configuration registers
  logic [ADDR_W-1:0]  offset_q;
  logic [COUNT_W-1:0] count_q;

  // search state
  logic [CW-1:0]             cursor_q, cursor_d;
  logic [CW-1:0]             end_q, end_d;
  logic [NEURON_ID_BITS-1:0] last_q, last_d;
  logic [TIME_W-1:0]         rtime_q, rtime_d;
  logic [CW-1:0]             idx_q, idx_d;
  logic [NEURON_ID_BITS-1:0] max_q, max_d;

  // memory ports
  logic                      wr_en;
  logic                      rd_en;
  logic [NEURON_ID_BITS-1:0] rd_src_q;
  logic [PAYLOAD_BITS-1:0]   rd_dat_q;

  // result registers
  logic                      res_load;
  logic                      found_q, found_d;
  logic [NEURON_ID_BITS-1:0] rsrc_q, rsrc_d;
  logic [PAYLOAD_BITS-1:0]   rdat_q, rdat_d;
  logic [ADDR_W-1:0]         ridx_q, ridx_d;
  status_e                   stat_q, stat_d;

  // checks and scan decisions
  logic          time_err;
  logic          back_err;
  logic          empty;
  logic          unord;
  logic          match;
  logic          greater;
  logic          at_end;
  logic [CW-1:0] idx_nxt;
  logic [WW-1:0] addr_w;
  logic [WW-1:0] region_end_w;

  assign addr_w       = WW'(addr_q);
  assign region_end_w = WW'(offset_q) + WW'(count_q);

  assign time_err = (time_q != rtime_q);
  assign back_err = (nid_q < last_q);
  assign empty    = (cursor_q >= end_q);

  assign unord   = (rd_src_q < max_q);
  assign match   = (rd_src_q == nid_q);
  assign greater = (rd_src_q > nid_q);
  assign idx_nxt = idx_q + CW'(1);
  assign at_end  = (idx_nxt >= end_q);

  assign sts_o.scan_needed = (op_q == OP_SEARCH) && !time_err && !back_err && !empty;
  assign sts_o.scan_done   = unord || match || greater || at_end;

  // operation and scan step
  always_comb begin
    cursor_d = cursor_q;
    end_d    = end_q;
    last_d   = last_q;
    rtime_d  = rtime_q;
    idx_d    = idx_q;
    max_d    = max_q;
    wr_en    = 1'b0;
    rd_en    = 1'b0;
    res_load = 1'b0;
    found_d  = 1'b0;
    rsrc_d   = '0;
    rdat_d   = '0;
    ridx_d   = '0;
    stat_d   = STAT_OK;
    if (cmd_i.exec) begin
      case (op_q)
        OP_LOAD: begin
          wr_en    = (addr_w < DEPTH_W);
          res_load = 1'b1;
        end
        OP_RESTART: begin
          cursor_d = (WW'(offset_q) > DEPTH_W) ? CW'(TABLE_DEPTH) : CW'(offset_q);
          end_d    = (region_end_w > DEPTH_W) ? CW'(TABLE_DEPTH) : CW'(region_end_w);
          rtime_d  = time_q;
          last_d   = '0;
          res_load = 1'b1;
        end
        OP_SEEK: begin
          cursor_d = (addr_w > DEPTH_W) ? CW'(TABLE_DEPTH) : CW'(addr_w);
          res_load = 1'b1;
        end
        OP_SEARCH: begin
          if (time_err) begin
            stat_d   = STAT_TIME;
            res_load = 1'b1;
          end else if (back_err) begin
            stat_d   = STAT_BACKWARD;
            res_load = 1'b1;
          end else if (empty) begin
            last_d   = nid_q;
            res_load = 1'b1;
          end else begin
            // first read at the cursor
            idx_d = cursor_q;
            max_d = '0;
            rd_en = 1'b1;
          end
        end
        default: begin
          res_load = 1'b1;
        end
      endcase
    end else if (cmd_i.scan) begin
      rsrc_d = rd_src_q;
      rdat_d = rd_dat_q;
      ridx_d = ADDR_W'(idx_q);
      if (unord) begin
        stat_d   = STAT_UNORDERED;
        res_load = 1'b1;
      end else if (match) begin
        found_d  = 1'b1;
        last_d   = nid_q;
        cursor_d = idx_nxt;
        res_load = 1'b1;
      end else if (greater) begin
        last_d   = nid_q;
        cursor_d = idx_q;
        res_load = 1'b1;
      end else if (at_end) begin
        last_d   = nid_q;
        cursor_d = end_q;
        res_load = 1'b1;
      end else begin
        // read the next entry
        idx_d = idx_nxt;
        max_d = rd_src_q;
        rd_en = 1'b1;
      end
    end
  end

  // table memory, one access a cycle, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      src_mem[IW'(addr_q)] <= esrc_q;
      dat_mem[IW'(addr_q)] <= edat_q;
    end
    if (rd_en) begin
      rd_src_q <= src_mem[IW'(idx_d)];
      rd_dat_q <= dat_mem[IW'(idx_d)];
    end
  end

  // transaction capture and scan registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= op_e'(op_i);
      addr_q <= address_i;
      esrc_q <= entry_source_i;
      edat_q <= entry_data_i;
      nid_q  <= neuron_id_i;
      time_q <= time_ms_i;
    end
    idx_q <= idx_d;
    max_q <= max_d;
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      found_q <= found_d;
      rsrc_q  <= rsrc_d;
      rdat_q  <= rdat_d;
      ridx_q  <= ridx_d;
      stat_q  <= stat_d;
    end
  end

  // configuration and search state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      count_q  <= '0;
      cursor_q <= '0;
      end_q    <= '0;
      last_q   <= '0;
      rtime_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_TABLE_OFFSET: offset_q <= cfg_data_i[ADDR_W-1:0];
          CFG_TABLE_COUNT:  count_q  <= cfg_data_i;
          default:          count_q  <= count_q;
        endcase
      end
      cursor_q <= cursor_d;
      end_q    <= end_d;
      last_q   <= last_d;
      rtime_q  <= rtime_d;
    end
  end

  assign found_o         = found_q;
  assign result_source_o = rsrc_q;
  assign result_data_o   = rdat_q;
  assign result_index_o  = ridx_q;
  assign status_o        = stat_q;

endmodule

`default_nettype wire

@@ src/sorted_table_forward_search_unit.sv @@
// top level of the sorted table forward search unit
//
// channel   direction  handshake                      payload
// command   in         start && !busy                 op, address, entry, neuron id, time
// config    in         cfg_valid_i && cfg_ready_o     cfg_index_i, cfg_data_i
// result    out        result_valid_o (one cycle)     found, source, data, index, status
//
// load, restart, seek and rejected searches: the accepted command passes the execute
// state and the registered result strobe rises as the unit returns to idle; a new
// command is taken in the strobe cycle; a search reads the table entries one entry a cycle
// through the single table read port
// reset clears configuration, cursor, region end, last query and restart time, not the table
// the receiver cannot stall; config writes are always ready
`default_nettype none

module sorted_table_forward_search_unit
  import stfs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH    = DEF_TABLE_DEPTH,
  parameter int unsigned NEURON_ID_BITS = DEF_NEURON_ID_BITS,
  parameter int unsigned PAYLOAD_BITS   = DEF_PAYLOAD_BITS
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  // command channel
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [1:0]                op_i,
  input  wire logic [ADDR_W-1:0]         address_i,
  input  wire logic [NEURON_ID_BITS-1:0] entry_source_i,
  input  wire logic [PAYLOAD_BITS-1:0]   entry_data_i,
  input  wire logic [NEURON_ID_BITS-1:0] neuron_id_i,
  input  wire logic [TIME_W-1:0]         time_ms_i,
  // configuration channel
  input  wire logic                      cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire logic                      cfg_index_i,
  input  wire logic [COUNT_W-1:0]        cfg_data_i,
  // result channel
  output logic                           result_valid_o,
  output logic                           found_o,
  output logic [NEURON_ID_BITS-1:0]      result_source_o,
  output logic [PAYLOAD_BITS-1:0]        result_data_o,
  output logic [ADDR_W-1:0]              result_index_o,
  output logic [1:0]                     status_o
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  // controller
  stfs_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  // datapath
  stfs_datapath #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .NEURON_ID_BITS (NEURON_ID_BITS),
    .PAYLOAD_BITS   (PAYLOAD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .op_i            (op_i),
    .address_i       (address_i),
    .entry_source_i  (entry_source_i),
    .entry_data_i    (entry_data_i),
    .neuron_id_i     (neuron_id_i),
    .time_ms_i       (time_ms_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .found_o         (found_o),
    .result_source_o (result_source_o),
    .result_data_o   (result_data_o),
    .result_index_o  (result_index_o),
    .status_o        (status_o)
  );

`ifndef SYNTHESIS
  // an accepted transaction makes the unit busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // every result follows a busy cycle
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result strobe without a transaction in flight");

  // a match is always reported with ok status
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && found_o |-> status_o == STAT_OK)
    else $error("found reported with an error status");

  // the result strobe is a single cycle pulse per transaction
  a_strobe_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !busy |=> !result_valid_o)
    else $error("result strobe held without a new transaction");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the sorted table forward search unit

module tb_top;
  import stfs_pkg::*;

  localparam int unsigned DEPTH = DEF_TABLE_DEPTH;
  localparam int unsigned NID_W = DEF_NEURON_ID_BITS;
  localparam int unsigned PAY_W = DEF_PAYLOAD_BITS;
  localparam int unsigned NID_TOP = 24'hFF_FFFF;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // one queued transaction: a register write or a command
  typedef struct packed {
    logic               is_reg;
    cfg_idx_e           reg_idx;
    logic [COUNT_W-1:0] reg_val;
    op_e                op;
    logic [ADDR_W-1:0]  addr;
    logic [NID_W-1:0]   src;
    logic [PAY_W-1:0]   data;
    logic [NID_W-1:0]   nid;
    logic [TIME_W-1:0]  tms;
  } stim_t;

  // one result transaction
  typedef struct packed {
    logic              found;
    logic [NID_W-1:0]  source;
    logic [PAY_W-1:0]  data;
    logic [ADDR_W-1:0] index;
    status_e           status;
  } lookup_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  stim_t cmd_item = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  stim_t cfg_item = '0;
  logic res_valid;
  logic res_found;
  logic [NID_W-1:0] res_source;
  logic [PAY_W-1:0] res_data;
  logic [ADDR_W-1:0] res_index;
  logic [1:0] res_status;

  logic cmd_fire = 1'b0;
  logic cfg_fire = 1'b0;
  int unsigned quiet = 0;
  int unsigned n_sent = 0;
  int unsigned n_total = 0;
  int unsigned mismatches = 0;

  stim_t pending_q[$];
  lookup_t expect_q[$];

  // predictor state
  logic [NID_W-1:0] tbl_src [DEPTH];
  logic [PAY_W-1:0] tbl_dat [DEPTH];
  int unsigned scan_cursor = 0;
  int unsigned region_end = 0;
  logic [NID_W-1:0] last_nid = '0;
  logic [TIME_W-1:0] restart_ms = '0;
  logic [ADDR_W-1:0] region_offset = '0;
  logic [COUNT_W-1:0] region_count = '0;

  // stimulus shaping state: which entries were loaded, where a scan may begin
  bit gen_loaded [DEPTH];
  int unsigned gen_lb = 0;
  int unsigned gen_end = 0;
  int unsigned gen_off = 0;
  int unsigned gen_cnt = 0;
  int unsigned phase_lo = 0;
  int unsigned n_cmds = 0;

  always #5 clk_i = ~clk_i;

  sorted_table_forward_search_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .op_i           (cmd_item.op),
    .address_i      (cmd_item.addr),
    .entry_source_i (cmd_item.src),
    .entry_data_i   (cmd_item.data),
    .neuron_id_i    (cmd_item.nid),
    .time_ms_i      (cmd_item.tms),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_item.reg_idx),
    .cfg_data_i     (cfg_item.reg_val),
    .result_valid_o (res_valid),
    .found_o        (res_found),
    .result_source_o(res_source),
    .result_data_o  (res_data),
    .result_index_o (res_index),
    .status_o       (res_status)
  );

  // expected result of one command, advancing the predictor state
  task automatic search_predict(input stim_t c, output lookup_t r);
    int unsigned i, peak, lim;
    logic [NID_W-1:0] s;
    logic done;
    r = '0;
    r.status = STAT_OK;
    case (c.op)
      OP_LOAD: begin
        tbl_src[c.addr] = c.src;
        tbl_dat[c.addr] = c.data;
      end
      OP_RESTART: begin
        // offset is 12 bit so it never exceeds the depth
        lim = int'(region_offset) + int'(region_count);
        scan_cursor = int'(region_offset);
        region_end = (lim > DEPTH) ? DEPTH : lim;
        restart_ms = c.tms;
        last_nid = '0;
      end
      OP_SEEK: scan_cursor = int'(c.addr);
      default: begin
        if (c.tms != restart_ms) begin
          r.status = STAT_TIME;
        end else if (c.nid < last_nid) begin
          r.status = STAT_BACKWARD;
        end else if (scan_cursor >= region_end) begin
          // nothing left to read
          last_nid = c.nid;
        end else begin
          peak = 0;
          i = scan_cursor;
          done = 1'b0;
          while (!done && i < region_end) begin
            s = tbl_src[i];
            r.source = s;
            r.data = tbl_dat[i];
            r.index = ADDR_W'(i);
            if (int'(s) < peak) begin
              // descending source: table out of order, cursor kept
              r.status = STAT_UNORDERED;
              done = 1'b1;
            end else if (s >= c.nid) begin
              r.found = (s == c.nid);
              last_nid = c.nid;
              scan_cursor = (s == c.nid) ? i + 1 : i;
              done = 1'b1;
            end else begin
              peak = int'(s);
              i++;
            end
          end
          // ran off the region end, last entry read stays reported
          if (!done) begin
            last_nid = c.nid;
            scan_cursor = region_end;
          end
        end
      end
    endcase
  endtask

  function automatic bit span_written(int unsigned lo, int unsigned hi);
    for (int unsigned i = lo; i < hi; i++) begin
      if (!gen_loaded[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic queue_register(cfg_idx_e idx, int unsigned v);
    stim_t it;
    it = '0;
    it.is_reg = 1'b1;
    it.reg_idx = idx;
    it.reg_val = COUNT_W'(v);
    if (idx == CFG_TABLE_OFFSET) gen_off = v;
    else gen_cnt = v;
    pending_q.push_back(it);
  endtask

  // fields the operation does not use get random values
  task automatic queue_command(op_e op, int unsigned a, int unsigned s, logic [PAY_W-1:0] d,
                               int unsigned q, logic [TIME_W-1:0] t);
    stim_t it, fix;
    int unsigned lim;
    it = '0;
    it.op = op;
    it.addr = (op == OP_LOAD || op == OP_SEEK) ? ADDR_W'(a) : ADDR_W'($urandom);
    it.src = (op == OP_LOAD) ? NID_W'(s) : NID_W'($urandom);
    it.data = (op == OP_LOAD) ? d : PAY_W'($urandom);
    it.nid = (op == OP_SEARCH) ? NID_W'(q) : NID_W'($urandom);
    it.tms = (op == OP_RESTART || op == OP_SEARCH) ? t : TIME_W'($urandom);
    case (op)
      OP_LOAD: gen_loaded[it.addr] = 1'b1;
      OP_RESTART: begin
        lim = gen_off + gen_cnt;
        gen_lb = gen_off;
        gen_end = (lim > DEPTH) ? DEPTH : lim;
      end
      OP_SEEK: gen_lb = a;
      default: begin
        // keep every scan inside loaded entries
        if (!span_written(gen_lb, gen_end)) begin
          fix = it;
          fix.op = OP_SEEK;
          fix.addr = ADDR_W'(phase_lo);
          pending_q.push_back(fix);
          gen_lb = phase_lo;
          n_cmds++;
        end
      end
    endcase
    pending_q.push_back(it);
    n_cmds++;
  endtask

  // accept transactions, predict and check results
  always @(posedge clk_i) begin
    lookup_t want, got;
    cmd_fire <= rst_ni && start && !busy;
    cfg_fire <= rst_ni && cfg_valid && cfg_ready;
    if (rst_ni) begin
      if (res_valid) begin
        got.found = res_found;
        got.source = res_source;
        got.data = res_data;
        got.index = res_index;
        got.status = status_e'(res_status);
        if (expect_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%t unexpected result: f=%0d src=%h dat=%h idx=%0d st=%0d", $realtime,
                     got.found, got.source, got.data, got.index, got.status);
        end else begin
          want = expect_q.pop_front();
          if (got.found !== want.found || got.source !== want.source ||
              got.data !== want.data || got.index !== want.index ||
              got.status !== want.status) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%t exp f=%0d s=%h d=%h i=%0d st=%0d got f=%0d s=%h d=%h i=%0d st=%0d",
                       $realtime, want.found, want.source, want.data, want.index,
                       want.status, got.found, got.source, got.data, got.index, got.status);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_item.reg_idx == CFG_TABLE_OFFSET) region_offset = cfg_item.reg_val[ADDR_W-1:0];
        else region_count = cfg_item.reg_val;
      end
      if (start && !busy) begin
        search_predict(cmd_item, want);
        expect_q.push_back(want);
      end
    end
  end

  // drive pending transactions; register writes wait until the block is idle
  always @(negedge clk_i) begin
    logic nx_start, nx_cfg;
    int unsigned idle_pct;
    if (rst_ni) begin
      nx_start = start && !cmd_fire;
      nx_cfg = cfg_valid && !cfg_fire;
      idle_pct = (n_sent < n_total / 3) ? 10 : (n_sent < 2 * n_total / 3) ? 84 : 0;
      if (!nx_start && !nx_cfg && pending_q.size() != 0) begin
        if (pending_q[0].is_reg) begin
          if (expect_q.size() != 0) begin
            quiet <= 0;
          end else if (quiet < SETTLE_CYCLES) begin
            quiet <= quiet + 1;
          end else begin
            cfg_item <= pending_q.pop_front();
            nx_cfg = 1'b1;
            quiet <= 0;
          end
        end else if ($urandom_range(99, 0) >= idle_pct) begin
          cmd_item <= pending_q.pop_front();
          nx_start = 1'b1;
          n_sent <= n_sent + 1;
        end
      end
      start <= nx_start;
      cfg_valid <= nx_cfg;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned off, cnt, reg_end, lo, base, cur_src, v, q, a, nsearch, r, sel;
    logic [TIME_W-1:0] t;

    // directed: region at the top of the table, end saturates at the depth
    queue_register(CFG_TABLE_OFFSET, 4093);
    queue_register(CFG_TABLE_COUNT, 4096);
    phase_lo = 4093;
    queue_command(OP_LOAD, 4093, 0, '1, 0, '0);
    queue_command(OP_LOAD, 4094, 5, '0, 0, '0);
    queue_command(OP_LOAD, 4095, NID_TOP, PAY_W'($urandom), 0, '0);
    // cursor already at the end before any restart
    queue_command(OP_SEARCH, 0, 0, '0, 0, '0);
    // wrong time
    queue_command(OP_SEARCH, 0, 0, '0, NID_TOP, TIME_W'(1));
    queue_command(OP_RESTART, 0, 0, '0, 0, TIME_MAX);
    queue_command(OP_SEARCH, 0, 0, '0, 0, TIME_MAX);
    // stops at a larger source
    queue_command(OP_SEARCH, 0, 0, '0, 3, TIME_MAX);
    // backward query
    queue_command(OP_SEARCH, 0, 0, '0, 2, TIME_MAX);
    queue_command(OP_SEARCH, 0, 0, '0, NID_TOP, TIME_MAX);
    queue_command(OP_SEARCH, 0, 0, '0, NID_TOP, TIME_MAX);
    queue_command(OP_SEEK, 4094, 0, '0, 0, '0);
    queue_command(OP_SEARCH, 0, 0, '0, NID_TOP, TIME_MAX);
    // out of order entries
    queue_command(OP_LOAD, 4094, 24'h10, PAY_W'($urandom), 0, '0);
    queue_command(OP_LOAD, 4095, 5, PAY_W'($urandom), 0, '0);
    queue_command(OP_RESTART, 0, 0, '0, 0, TIME_MAX);
    queue_command(OP_SEARCH, 0, 0, '0, 24'h20, TIME_MAX);
    // ordered again, scan runs off the end without a match
    queue_command(OP_LOAD, 4094, 3, PAY_W'($urandom), 0, '0);
    queue_command(OP_SEARCH, 0, 0, '0, 9, TIME_MAX);
    queue_command(OP_SEEK, 0, 0, '0, 0, '0);

    // random phases: configure, load a sorted region, restart, walk it
    for (int ph = 0; n_cmds < 720; ph++) begin
      case (ph)
        0: begin off = 0; cnt = 4096; end
        1: begin off = 4095; cnt = 4096; end
        2: begin off = $urandom_range(4095, 0); cnt = 0; end
        3: begin off = 0; cnt = $urandom_range(24, 1); end
        default: begin
          sel = $urandom_range(15, 0);
          off = $urandom_range(4095, 0);
          cnt = (sel == 0) ? 4096 : (sel == 1) ? 0 : $urandom_range(40, 1);
        end
      endcase
      queue_register(CFG_TABLE_OFFSET, off);
      queue_register(CFG_TABLE_COUNT, cnt);
      reg_end = (off + cnt > DEPTH) ? DEPTH : off + cnt;
      // huge regions: only a short tail is loaded and searched
      lo = (reg_end - off > 48) ? reg_end - $urandom_range(40, 8) : off;
      phase_lo = lo;
      sel = $urandom_range(7, 0);
      base = (sel == 0) ? 0 : (sel == 1) ? NID_TOP - 60 : $urandom_range(NID_TOP - 256, 0);
      cur_src = base;
      for (a = lo; a < reg_end; a++) begin
        if ($urandom_range(99, 0) < 4) begin
          v = $urandom_range(NID_TOP, 0);
        end else begin
          if ($urandom_range(2, 0) != 0) cur_src += $urandom_range(3, 1);
          if (cur_src > NID_TOP) cur_src = NID_TOP;
          v = cur_src;
        end
        queue_command(OP_LOAD, a, v, PAY_W'($urandom), 0, '0);
      end
      sel = $urandom_range(9, 0);
      t = (sel == 0) ? '0 : (sel == 1) ? TIME_MAX : TIME_W'($urandom);
      queue_command(OP_RESTART, 0, 0, '0, 0, t);
      if (lo != off) queue_command(OP_SEEK, lo, 0, '0, 0, '0);
      q = (base > 2) ? base - $urandom_range(2, 0) : base;
      nsearch = (reg_end - lo) + $urandom_range(8, 2);
      for (int k = 0; k < nsearch; k++) begin
        r = $urandom_range(99, 0);
        if (r < 5) begin
          queue_command(OP_SEARCH, 0, 0, '0, q, t + TIME_W'($urandom_range(1000, 1)));
        end else if (r < 10 && q > 0) begin
          queue_command(OP_SEARCH, 0, 0, '0, q - $urandom_range((q < 5) ? q : 5, 1), t);
        end else if (r < 14) begin
          a = $urandom_range(reg_end, lo);
          queue_command(OP_SEEK, (a > 4095) ? 4095 : a, 0, '0, 0, '0);
        end else if (r < 16) begin
          a = $urandom_range(4095, 0);
          if (a < gen_end && !span_written(a, gen_end)) a = phase_lo;
          queue_command(OP_SEEK, a, 0, '0, 0, '0);
        end else if (r < 18) begin
          t = TIME_W'($urandom);
          queue_command(OP_RESTART, 0, 0, '0, 0, t);
          if (lo != off) queue_command(OP_SEEK, lo, 0, '0, 0, '0);
          q = base;
        end else if (r < 21) begin
          queue_command(OP_LOAD, $urandom_range(4095, 0), $urandom_range(NID_TOP, 0),
                        PAY_W'($urandom), 0, '0);
        end else begin
          q += ($urandom_range(9, 0) == 0) ? $urandom_range(200, 0) : $urandom_range(2, 0);
          if (q > NID_TOP) q = NID_TOP;
          queue_command(OP_SEARCH, 0, 0, '0, q, t);
        end
      end
    end
    n_total = n_cmds;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_q.size() != 0 || start || cfg_valid || expect_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
